>>> rtl/cfxd_pkg.sv
package cfxd_pkg;

  // Segment buffer geometry.
  localparam int SEG_DEPTH = 62;
  localparam int SEG_AW    = $clog2(SEG_DEPTH);
  localparam int LEN_W     = $clog2(SEG_DEPTH + 1);
  // The drain counter runs over the payload plus CR and LF.
  localparam int CNT_W     = $clog2(SEG_DEPTH + 3);

  // Configuration port.
  localparam int CFG_DW = 64;
  localparam int CFG_AW = 4;
  // Byte address bit that selects the register slot (8 bytes per slot).
  localparam int CFG_IDX_BIT = 3;
  localparam logic REG_XOR_KEY = 1'b0;
  localparam logic [CFG_DW-1:0] XOR_KEY_RST = 64'h0504_0D07_0809_0A0B;

  // Marker and line-end characters.
  localparam logic [7:0] CH_LT   = 8'h3C;  // '<'
  localparam logic [7:0] CH_BANG = 8'h21;  // '!'
  localparam logic [7:0] CH_DASH = 8'h2D;  // '-'
  localparam logic [7:0] CH_GT   = 8'h3E;  // '>'
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_LF   = 8'h0A;

  // Top-level sequencer states.
  typedef enum logic [1:0] {
    ST_SCAN  = 2'b01,
    ST_DRAIN = 2'b10
  } state_t;

endpackage

>>> rtl/cfxd_ram.sv
module cfxd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 62,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port; read data holds when idle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/comment_framed_xor_deframer.sv
// Comment-framed XOR deframer.
//
// The in_ channel takes one raw byte per item and scans it for "<!--" ... "-->"
// frames. Payload bytes of the current frame are written into a 62-entry
// segment RAM as they settle (two bytes after arrival). While scanning, one
// item is accepted every cycle.
//
// On a close marker that has a valid opener, in_tready drops and the stored
// payload is read back one entry per cycle, unless the receiver stalls,
// through the RAM's single read port, XORed with the 8-byte key and sent on
// the out_ channel, followed by CR and LF (tlast on the LF). The input stays
// held until the LF has been issued to the read stage. After the close byte
// is accepted, the first result passes from the sequencer through the read
// stage into the output register. tuser flags a frame whose payload overflowed
// the buffer. A close without an opener emits nothing and does not stall.
//
// A stall on out_tready backs up the RAM read stage and then the sequencer;
// nothing is dropped. Synchronous reset restores the key and clears all
// scanning state; the RAM needs no clearing pass.
module comment_framed_xor_deframer (
  input  logic                          clk,
  input  logic                          rst_n,
  // Input item stream.
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [7:0]                    in_tdata,   // [7:0] in_byte
  // Result item stream.
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [7:0]                    out_tdata,  // [7:0] out_byte
  output logic                          out_tlast,
  output logic                          out_tuser,  // [0] truncated
  // Configuration port.
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [cfxd_pkg::CFG_AW-1:0]   cfg_paddr,
  input  logic [cfxd_pkg::CFG_DW-1:0]   cfg_pwdata,
  output logic [cfxd_pkg::CFG_DW-1:0]   cfg_prdata,
  output logic                          cfg_pready
);

  import cfxd_pkg::*;

  // Configuration register.
  logic [CFG_DW-1:0] xor_key_r;
  logic              cfg_sel_key;

  assign cfg_pready  = 1'b1;
  assign cfg_sel_key = (cfg_paddr[CFG_IDX_BIT] == REG_XOR_KEY);
  assign cfg_prdata  = cfg_sel_key ? xor_key_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xor_key_r <= XOR_KEY_RST;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_sel_key) begin
      xor_key_r <= cfg_pwdata;
    end
  end

  // Scanner state.
  state_t            state_r, state_nxt;
  logic [23:0]       window_r, window_nxt;
  logic [2:0]        bsc_r, bsc_nxt;
  logic              opener_seen_r, opener_seen_nxt;
  logic [LEN_W-1:0]  seg_len_r, seg_len_nxt;
  logic              seg_ovf_r, seg_ovf_nxt;
  logic [1:0]        tags_r, tags_nxt;

  // Drain sequencer state.
  logic [LEN_W-1:0]  drain_len_r, drain_len_nxt;
  logic              drain_trunc_r, drain_trunc_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;

  // Read stage (aligned with RAM read data) and output register.
  logic              p1_valid_r, p1_valid_nxt;
  logic              p1_mem_r, p1_mem_nxt;
  logic [2:0]        p1_kidx_r, p1_kidx_nxt;
  logic [7:0]        p1_byte_r, p1_byte_nxt;
  logic              p1_last_r, p1_last_nxt;
  logic              p1_trunc_r, p1_trunc_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [7:0]        out_byte_r, out_byte_nxt;
  logic              out_last_r, out_last_nxt;
  logic              out_trunc_r, out_trunc_nxt;

  // RAM ports.
  logic              ram_we, ram_re;
  logic [SEG_AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]        ram_wdata, ram_rdata;

  logic              in_fire, is_close, opener_now, load, issue;
  logic [7:0]        c1, c2, c3, key_byte;

  assign in_tready  = (state_r == ST_SCAN);
  assign in_fire    = in_tvalid && in_tready;
  assign c1         = window_r[7:0];
  assign c2         = window_r[15:8];
  assign c3         = window_r[23:16];
  assign is_close   = (bsc_r >= 3'd2) && (c2 == CH_DASH) && (c1 == CH_DASH)
                      && (in_tdata == CH_GT);
  assign opener_now = (bsc_r >= 3'd3) && (c3 == CH_LT) && (c2 == CH_BANG)
                      && (c1 == CH_DASH) && (in_tdata == CH_DASH);

  // The output register takes the read stage whenever it is free or emptying.
  assign load  = p1_valid_r && (!out_valid_r || out_tready);
  assign issue = (state_r == ST_DRAIN) && (!p1_valid_r || load);

  assign key_byte  = xor_key_r[8*p1_kidx_r +: 8];
  assign ram_waddr = seg_len_r[SEG_AW-1:0];
  assign ram_wdata = c2;
  assign ram_raddr = cnt_r[SEG_AW-1:0];

  // Scanning: window shift, marker detection and payload capture; then drain sequencing.
  always_comb begin
    state_nxt       = state_r;
    window_nxt      = window_r;
    bsc_nxt         = bsc_r;
    opener_seen_nxt = opener_seen_r;
    seg_len_nxt     = seg_len_r;
    seg_ovf_nxt     = seg_ovf_r;
    tags_nxt        = tags_r;
    drain_len_nxt   = drain_len_r;
    drain_trunc_nxt = drain_trunc_r;
    cnt_nxt         = cnt_r;
    ram_we          = 1'b0;
    ram_re          = 1'b0;
    p1_valid_nxt    = p1_valid_r && !load;
    p1_mem_nxt      = p1_mem_r;
    p1_kidx_nxt     = p1_kidx_r;
    p1_byte_nxt     = p1_byte_r;
    p1_last_nxt     = p1_last_r;
    p1_trunc_nxt    = p1_trunc_r;

    if (in_fire) begin
      window_nxt = {window_r[15:0], in_tdata};
      if (is_close) begin
        // A close starts a drain only if an opener was confirmed.
        if (opener_seen_r) begin
          drain_len_nxt   = seg_len_r;
          drain_trunc_nxt = seg_ovf_r;
          cnt_nxt         = '0;
          state_nxt       = ST_DRAIN;
        end
        opener_seen_nxt = 1'b0;
        seg_len_nxt     = '0;
        seg_ovf_nxt     = 1'b0;
        tags_nxt        = '0;
        bsc_nxt         = '0;
      end else begin
        // Settle the byte two positions back.
        if (bsc_r >= 3'd2) begin
          if (tags_r[1]) begin
            opener_seen_nxt = 1'b1;
            seg_len_nxt     = '0;
            seg_ovf_nxt     = 1'b0;
          end else if (opener_seen_r) begin
            if (seg_len_r < LEN_W'(SEG_DEPTH)) begin
              ram_we      = 1'b1;
              seg_len_nxt = seg_len_r + 1'b1;
            end else begin
              seg_ovf_nxt = 1'b1;
            end
          end
        end
        tags_nxt = {tags_r[0], opener_now};
        if (bsc_r != 3'd7) begin
          bsc_nxt = bsc_r + 3'd1;
        end
      end
    end

    // Drain: payload reads from the RAM, then CR, then LF.
    if (issue) begin
      p1_valid_nxt = 1'b1;
      p1_trunc_nxt = drain_trunc_r;
      p1_kidx_nxt  = cnt_r[2:0];
      cnt_nxt      = cnt_r + 1'b1;
      if (cnt_r < CNT_W'(drain_len_r)) begin
        ram_re      = 1'b1;
        p1_mem_nxt  = 1'b1;
        p1_last_nxt = 1'b0;
      end else if (cnt_r == CNT_W'(drain_len_r)) begin
        p1_mem_nxt  = 1'b0;
        p1_byte_nxt = CH_CR;
        p1_last_nxt = 1'b0;
      end else begin
        p1_mem_nxt  = 1'b0;
        p1_byte_nxt = CH_LF;
        p1_last_nxt = 1'b1;
        state_nxt   = ST_SCAN;
      end
    end
  end

  // Output register.
  always_comb begin
    out_valid_nxt = out_valid_r && !out_tready;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    out_trunc_nxt = out_trunc_r;
    if (load) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = p1_mem_r ? (ram_rdata ^ key_byte) : p1_byte_r;
      out_last_nxt  = p1_last_r;
      out_trunc_nxt = p1_trunc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_SCAN;
      window_r      <= '0;
      bsc_r         <= '0;
      opener_seen_r <= 1'b0;
      seg_len_r     <= '0;
      seg_ovf_r     <= 1'b0;
      tags_r        <= '0;
      cnt_r         <= '0;
      p1_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      window_r      <= window_nxt;
      bsc_r         <= bsc_nxt;
      opener_seen_r <= opener_seen_nxt;
      seg_len_r     <= seg_len_nxt;
      seg_ovf_r     <= seg_ovf_nxt;
      tags_r        <= tags_nxt;
      cnt_r         <= cnt_nxt;
      p1_valid_r    <= p1_valid_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    drain_len_r   <= drain_len_nxt;
    drain_trunc_r <= drain_trunc_nxt;
    p1_mem_r      <= p1_mem_nxt;
    p1_kidx_r     <= p1_kidx_nxt;
    p1_byte_r     <= p1_byte_nxt;
    p1_last_r     <= p1_last_nxt;
    p1_trunc_r    <= p1_trunc_nxt;
    out_byte_r    <= out_byte_nxt;
    out_last_r    <= out_last_nxt;
    out_trunc_r   <= out_trunc_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_trunc_r;

  // Segment payload store.
  cfxd_ram #(
    .WIDTH (8),
    .DEPTH (SEG_DEPTH)
  ) u_seg_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

>>> rtl/cfxd_check.sv
module cfxd_check (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_tready,
  input logic                          out_tvalid,
  input logic                          out_tready,
  input logic [7:0]                    out_tdata,
  input logic                          out_tlast,
  input logic                          out_tuser
);

  import cfxd_pkg::*;

  // A result item that is not taken stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("out_tvalid dropped while stalled");

  // Its payload holds while stalled.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tlast)
                                   && $stable(out_tuser))
    else $error("result item changed while stalled");

  // Every segment ends on a line feed.
  a_last_is_lf: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tdata == CH_LF)
    else $error("tlast on a byte other than line feed");

  // Reset returns the block to scanning, ready for input.
  a_reset_ready: assert property (@(posedge clk)
    !rst_n |=> in_tready)
    else $error("input not ready after reset");

  // Reset leaves no result item pending.
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result item pending after reset");

endmodule

bind comment_framed_xor_deframer cfxd_check u_cfxd_check (.*);

>>> verif/comment_framed_xor_deframer_tb.sv
`timescale 1ns / 100ps

module comment_framed_xor_deframer_tb;
  import cfxd_pkg::*;

  localparam logic [CFG_AW-1:0] KEY_ADDR = CFG_AW'(REG_XOR_KEY) << CFG_IDX_BIT;
  // Cycles allowed after the last expected result before the block is called idle.
  localparam int SETTLE_CYCLES = 8;
  localparam int LONG_HOLD_CYCLES = 200;

  // One decoded result item as the out_ channel should deliver it.
  typedef struct {
    logic [7:0] data;
    bit         last;
    bit         trunc;
  } decoded_item_t;

  // Tracks the frame scanner and holds the decoded bytes still to come.
  class deframe_scoreboard;
    logic [63:0]   key;
    logic [23:0]   window;
    int unsigned   since_close;
    bit            opened;
    int unsigned   seg_len;
    bit            seg_over;
    logic [7:0]    seg_buf[SEG_DEPTH];
    bit [1:0]      opener_marks;
    decoded_item_t decoded_due[$];
    int unsigned   errors;

    function new();
      key          = XOR_KEY_RST;
      window       = '0;
      since_close  = 0;
      opened       = 1'b0;
      seg_len      = 0;
      seg_over     = 1'b0;
      opener_marks = '0;
      errors       = 0;
    endfunction

    function void set_key(logic [63:0] k);
      key = k;
    endfunction

    function void queue_byte(logic [7:0] d, bit l, bit t);
      decoded_item_t item;
      item.data  = d;
      item.last  = l;
      item.trunc = t;
      decoded_due.push_back(item);
    endfunction

    // Advance the scanner by one accepted input item.
    function void absorb_byte(logic [7:0] b);
      logic [7:0]  c1, c2, c3;
      int unsigned bsc;
      bit          opener_now;
      c1  = window[7:0];
      c2  = window[15:8];
      c3  = window[23:16];
      bsc = since_close;
      window = {window[15:0], b};

      // A close marker drains the segment if an opener has taken effect.
      if (bsc >= 2 && c2 == CH_DASH && c1 == CH_DASH && b == CH_GT) begin
        if (opened) begin
          for (int i = 0; i < seg_len; i++) begin
            queue_byte(seg_buf[i] ^ key[8*(i%8) +: 8], 1'b0, seg_over);
          end
          queue_byte(CH_CR, 1'b0, seg_over);
          queue_byte(CH_LF, 1'b1, seg_over);
        end
        opened       = 1'b0;
        seg_len      = 0;
        seg_over     = 1'b0;
        opener_marks = '0;
        since_close  = 0;
        return;
      end

      // The byte two positions back is now settled.
      if (bsc >= 2) begin
        if (opener_marks[1]) begin
          opened   = 1'b1;
          seg_len  = 0;
          seg_over = 1'b0;
        end else if (opened) begin
          if (seg_len < SEG_DEPTH) begin
            seg_buf[seg_len] = c2;
            seg_len++;
          end else begin
            seg_over = 1'b1;
          end
        end
      end

      opener_now = bsc >= 3 && c3 == CH_LT && c2 == CH_BANG && c1 == CH_DASH && b == CH_DASH;
      opener_marks = {opener_marks[0], opener_now};
      if (bsc < 7) since_close = bsc + 1;
    endfunction

    function void flag_mismatch(string what);
      errors++;
      if (errors <= 10) $display("MISMATCH at %0t: %s", $time, what);
    endfunction

    // Compare one delivered result item with the oldest one due.
    function void check_decoded(logic [7:0] d, logic l, logic t);
      decoded_item_t exp;
      if (decoded_due.size() == 0) begin
        flag_mismatch($sformatf("unexpected item data=%02h last=%0b trunc=%0b", d, l, t));
        return;
      end
      exp = decoded_due.pop_front();
      if (exp.data !== d || exp.last !== l || exp.trunc !== t) begin
        flag_mismatch($sformatf("expected data=%02h last=%0b trunc=%0b, got data=%02h last=%0b trunc=%0b",
                                exp.data, exp.last, exp.trunc, d, l, t));
      end
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [7:0]        in_tdata;    // [7:0] in_byte
  logic              out_tvalid;
  logic              out_tready;
  logic [7:0]        out_tdata;   // [7:0] out_byte
  logic              out_tlast;
  logic              out_tuser;   // [0] truncated
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [CFG_DW-1:0] cfg_pwdata;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  deframe_scoreboard sb = new();
  bit          calm;
  bit          long_hold_req;
  int unsigned items_sent;

  comment_framed_xor_deframer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #1000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Result receiver: random back-pressure, plus one long hold-off on request.
  initial begin
    int unsigned hold_left;
    hold_left  = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left     = LONG_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= rst_n && (calm || $urandom_range(99) >= 32);
      end
    end
  end

  // Every delivered item is checked at the edge that accepts it.
  always @(posedge clk) begin
    if (rst_n && out_tvalid === 1'b1 && out_tready) begin
      sb.check_decoded(out_tdata, out_tlast, out_tuser);
    end
  end

  // Offer one byte, with random gaps unless calm is set, and hold it until it is accepted.
  task automatic send_byte(input logic [7:0] b);
    while (!calm && $urandom_range(99) < 32) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.absorb_byte(b);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // Payload and noise bytes lean toward the marker characters.
  function automatic logic [7:0] pick_stream_byte();
    case ($urandom_range(9))
      0:       return CH_LT;
      1:       return CH_BANG;
      2, 3:    return CH_DASH;
      4:       return CH_GT;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic send_noise(input int unsigned n);
    for (int i = 0; i < n; i++) send_byte(pick_stream_byte());
  endtask

  // Wait until every decoded item has arrived and the block has settled.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (sb.decoded_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_key(input logic [63:0] k);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= KEY_ADDR;
    cfg_pwdata  <= k;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    sb.set_key(k);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // Mostly well-formed frames with random content, the rest noise and broken markers.
  task automatic run_frames(input int unsigned target, input bit force_long);
    int unsigned pick;
    int unsigned len;
    bit          long_done;
    long_done = !force_long;
    while (items_sent < target) begin
      pick = $urandom_range(99);
      if (pick < 60) begin
        if (!long_done || $urandom_range(29) == 0) len = $urandom_range(63, 70);
        else len = $urandom_range(0, 12);
        long_done = 1'b1;
        send_noise($urandom_range(0, 2));
        send_text("<!--");
        send_noise(len);
        send_text("-->");
      end else if (pick < 75) begin
        // A later opener replaces what the first one gathered.
        send_text("<!--");
        send_noise($urandom_range(0, 6));
        send_text("<!--");
        send_noise($urandom_range(0, 6));
        send_text("-->");
      end else if (pick < 85) begin
        case ($urandom_range(2))
          0:       send_text("<!-->");
          1:       send_text("<!--->");
          default: send_text("-->");
        endcase
      end else begin
        send_noise($urandom_range(1, 8));
      end
    end
  endtask

  initial begin
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    calm          = 1'b0;
    long_hold_req = 1'b0;
    items_sent    = 0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed frames under the reset key: byte extremes, an empty payload,
    // an opener that overlaps the close, and a close with no opener.
    send_text("<!--");
    send_byte(8'h00);
    send_byte(8'hFF);
    send_text("-->");
    send_text("<!---->");
    send_text("<!--<!-->");
    send_text("-->");
    wait_idle();

    // All-zero key, random idling, one frame long enough to overflow the buffer.
    write_key(64'h0);
    run_frames(items_sent + 75, 1'b1);
    wait_idle();

    // All-ones key with no idling on either side.
    write_key({64{1'b1}});
    calm = 1'b1;
    run_frames(items_sent + 75, 1'b0);
    wait_idle();

    // Random key, random idling, and a long receiver hold-off to back up the input.
    write_key({$urandom, $urandom});
    calm          = 1'b0;
    long_hold_req = 1'b1;
    run_frames(items_sent + 75, 1'b0);
    // An opener left unclosed must produce nothing.
    send_text("<!--ab");
    in_tvalid <= 1'b0;

    while (sb.decoded_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/cfxd_pkg.sv
rtl/cfxd_ram.sv
rtl/comment_framed_xor_deframer.sv
rtl/cfxd_check.sv
verif/comment_framed_xor_deframer_tb.sv
